// ----- rtl/peak_limiter_gain_ramp_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the peak limiter gain ramp core
// Shared helpers for writing clocked implication checks.
// ----------------------------------------------------------------------------
`ifndef PEAK_LIMITER_GAIN_RAMP_CORE_DEFINES_SVH
`define PEAK_LIMITER_GAIN_RAMP_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLGR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PLGR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- rtl/plgr_pkg.sv -----
// ----------------------------------------------------------------------------
// Peak limiter gain ramp package
// Shared types and fixed-point constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plgr_pkg;

  // Unity gain in Q16.16.
  localparam logic [31:0] ONE_Q16 = 32'd65536;

  // Width of a ramp factor; factors stay below 2.0.
  localparam int unsigned FW = 18;

  // Width of the shared divider's dividend and quotient (2^32 needs 33 bits).
  localparam int unsigned DIV_NW = 33;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_ROT
  } cell_op_e;

endpackage

`default_nettype wire

// ----- rtl/peak_limiter_gain_ramp_core.sv -----
// ----------------------------------------------------------------------------
// Peak limiter gain ramp core
// Lookahead peak limiter with a linear gain ramp around each peak.
// ----------------------------------------------------------------------------
// The block holds a window of 2*MAX_STEPS slots in a row of cells. Each input
// transfer pushes one slot (a sample, or an empty slot on a flush), after
// which the whole row rotates once through a single scaler at its head, one
// slot per cycle. The first pass finds the slot N-1 behind the newest and,
// when no peak is found there, picks up the slot 2N-1 behind the newest as
// the result. When the slot N-1 behind holds a sample above 1.0 in magnitude,
// a serial divider computes g = 1/|x| and then the ramp step, one multiply
// forms the starting factor, and a second pass scales each valid slot within
// the ramp and sets the peak to exactly plus or minus one. An item can also
// wait at the end until the output register frees up. The output register
// lets the next input transfer start while a result still waits.
// The ramp_steps register is written through its own channel, which is always
// ready; it is to be written only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module peak_limiter_gain_ramp_core import plgr_pkg::*; #(
  parameter int unsigned MAX_STEPS    = 64,
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // configuration write channel
  input  wire logic                    cfg_valid_i,
  output      logic                    cfg_ready_o,
  input  wire logic [6:0]              ramp_steps_i,
  // input channel
  input  wire logic                    in_valid_i,
  output      logic                    in_stall_o,
  input  wire logic                    kind_i,
  input  wire logic [SAMPLE_WIDTH-1:0] sample_in_i,
  // output channel
  output      logic                    out_valid_o,
  input  wire logic                    out_stall_i,
  output      logic [SAMPLE_WIDTH-1:0] sample_out_o
);

  localparam int unsigned DEPTH = 2 * MAX_STEPS;
  localparam int unsigned KW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW    = $clog2(MAX_STEPS + 2);
  localparam int unsigned W     = SAMPLE_WIDTH;

  localparam logic [W-1:0]  OneS = W'(ONE_Q16);
  localparam logic [FW-1:0] OneF = FW'(ONE_Q16);

  // Sequencer codes.
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRotA = 3'd1;
  localparam logic [2:0] StDivG = 3'd2;
  localparam logic [2:0] StDivR = 3'd3;
  localparam logic [2:0] StMult = 3'd4;
  localparam logic [2:0] StRotB = 3'd5;
  localparam logic [2:0] StDone = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [6:0]    ramp_q;
  logic [NW-1:0] n_q, n_d, n_eff;
  logic [KW-1:0] c_q, c_d, last_q, last_d;
  logic [KW-1:0] k_q, k_d;
  logic          peak_q, peak_d;
  logic [W-1:0]  pmag_q, pmag_d;
  logic          psign_q, psign_d;
  logic [15:0]   g_q, g_d;
  logic [16:0]   r_q, r_d;
  logic [FW-1:0] f_q, f_d;
  logic [W-1:0]  hold_q, hold_d;
  logic          hold_v_q, hold_v_d;
  logic [W-1:0]  out_q, out_d;
  logic          out_v_q, out_v_d;

  cell_op_e      cell_op;
  logic [W-1:0]  cell_data [DEPTH];
  logic          cell_valid [DEPTH];
  logic [W-1:0]  new_data;
  logic          new_valid;
  logic [W-1:0]  tail_data;
  logic          tail_valid;

  logic          div_start;
  logic [DIV_NW-1:0] div_dividend;
  logic [W-1:0]  div_divisor;
  logic          div_done;
  logic [DIV_NW-1:0] div_quot;

  // Head of the row and the scaler that sits in the rotation path.
  logic [W-1:0]      head_data;
  logic              head_valid;
  logic              head_neg;
  logic [W-1:0]      head_mag;
  logic [FW-1:0]     f_use;
  logic [W+FW-1:0]   prod;
  logic [W-1:0]      scaled_mag;
  logic [W-1:0]      scaled;
  logic [16+KW:0]    rc_prod;

  logic in_xfer;
  logic out_xfer;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_v_q && !out_stall_i;

  // Effective half width: 0 acts as 1, values above MAX_STEPS are clamped.
  always_comb begin
    if (ramp_q == 7'd0) begin
      n_eff = NW'(1);
    end else if (32'(ramp_q) > MAX_STEPS) begin
      n_eff = NW'(MAX_STEPS);
    end else begin
      n_eff = NW'(ramp_q);
    end
  end

  assign head_data  = cell_data[0];
  assign head_valid = cell_valid[0];
  assign head_neg   = head_data[W-1];
  assign head_mag   = head_neg ? (~head_data + 1'b1) : head_data;
  assign f_use      = (f_q > OneF) ? OneF : f_q;
  assign prod       = {{FW{1'b0}}, head_mag} * {{W{1'b0}}, f_use};
  assign scaled_mag = prod[W+15:16];
  assign scaled     = head_neg ? (~scaled_mag + 1'b1) : scaled_mag;
  assign rc_prod    = {{KW{1'b0}}, r_q} * {17'd0, c_q};

  assign new_data  = kind_i ? '0 : sample_in_i;
  assign new_valid = !kind_i;

  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    c_d          = c_q;
    last_d       = last_q;
    k_d          = k_q;
    peak_d       = peak_q;
    pmag_d       = pmag_q;
    psign_d      = psign_q;
    g_d          = g_q;
    r_d          = r_q;
    f_d          = f_q;
    hold_d       = hold_q;
    hold_v_d     = hold_v_q;
    out_d        = out_q;
    out_v_d      = out_v_q && !out_xfer;
    cell_op      = CELL_HOLD;
    tail_data    = head_data;
    tail_valid   = head_valid;
    div_start    = 1'b0;
    div_dividend = {1'b1, {(DIV_NW-1){1'b0}}};
    div_divisor  = pmag_q;

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          cell_op  = CELL_PUSH;
          n_d      = n_eff;
          c_d      = KW'(32'(n_eff) - 32'd1);
          last_d   = KW'((32'(n_eff) << 1) - 32'd1);
          k_d      = '0;
          peak_d   = 1'b0;
          hold_v_d = 1'b0;
          state_d  = StRotA;
        end
      end
      StRotA: begin
        // First pass: find the check slot and, without a peak, take out the result.
        cell_op = CELL_ROT;
        if (k_q == c_q) begin
          pmag_d  = head_mag;
          psign_d = head_neg;
          peak_d  = head_valid && (32'(head_mag) > ONE_Q16);
        end
        if ((k_q == last_q) && !peak_q) begin
          tail_valid = 1'b0;
          hold_d     = head_data;
          hold_v_d   = head_valid;
        end
        k_d = k_q + 1'b1;
        if (k_q == KW'(DEPTH - 1)) begin
          if (peak_q) begin
            div_start = 1'b1;
            state_d   = StDivG;
          end else begin
            state_d = StDone;
          end
        end
      end
      StDivG: begin
        if (div_done) begin
          g_d          = div_quot[15:0];
          div_start    = 1'b1;
          div_dividend = DIV_NW'(ONE_Q16 - 32'(div_quot[15:0]));
          div_divisor  = W'(32'(n_q) + 32'd1);
          state_d      = StDivR;
        end
      end
      StDivR: begin
        div_dividend = DIV_NW'(ONE_Q16 - 32'(g_q));
        div_divisor  = W'(32'(n_q) + 32'd1);
        if (div_done) begin
          r_d     = div_quot[16:0];
          state_d = StMult;
        end
      end
      StMult: begin
        // Starting factor at slot 0 is g + r*c; it stays below 2.0.
        f_d     = FW'(g_q) + rc_prod[FW-1:0];
        k_d     = '0;
        state_d = StRotB;
      end
      StRotB: begin
        cell_op = CELL_ROT;
        if (head_valid && (k_q <= last_q)) begin
          if (k_q == c_q) begin
            tail_data = psign_q ? (~OneS + 1'b1) : OneS;
          end else begin
            tail_data = scaled;
          end
        end
        if (k_q == last_q) begin
          tail_valid = 1'b0;
          hold_d     = tail_data;
          hold_v_d   = head_valid;
        end
        // Walk the factor down toward the peak and back up after it.
        if (k_q < c_q) begin
          f_d = f_q - FW'(r_q);
        end else if (k_q < last_q) begin
          f_d = f_q + FW'(r_q);
        end
        k_d = k_q + 1'b1;
        if (k_q == KW'(DEPTH - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!hold_v_q) begin
          state_d = StIdle;
        end else if (!out_v_q || !out_stall_i) begin
          out_d    = hold_q;
          out_v_d  = 1'b1;
          hold_v_d = 1'b0;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ramp_q   <= 7'd8;
      peak_q   <= 1'b0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      k_q      <= '0;
    end else begin
      state_q  <= state_d;
      peak_q   <= peak_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
      k_q      <= k_d;
      if (cfg_valid_i) begin
        ramp_q <= ramp_steps_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    c_q     <= c_d;
    last_q  <= last_d;
    pmag_q  <= pmag_d;
    psign_q <= psign_d;
    g_q     <= g_d;
    r_q     <= r_d;
    f_q     <= f_d;
    hold_q  <= hold_d;
    out_q   <= out_d;
  end

  // Row of window cells: slot 0 is the newest item and the rotation head.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] push_data;
    logic         push_valid;
    logic [W-1:0] rot_data;
    logic         rot_valid;

    if (i == 0) begin : g_first
      assign push_data  = new_data;
      assign push_valid = new_valid;
    end else begin : g_mid
      assign push_data  = cell_data[i-1];
      assign push_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rot_data  = tail_data;
      assign rot_valid = tail_valid;
    end else begin : g_inner
      assign rot_data  = cell_data[i+1];
      assign rot_valid = cell_valid[i+1];
    end

    plgr_cell #(
      .SAMPLE_WIDTH(W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (cell_op),
      .push_data_i (push_data),
      .push_valid_i(push_valid),
      .rot_data_i  (rot_data),
      .rot_valid_i (rot_valid),
      .data_o      (cell_data[i]),
      .valid_o     (cell_valid[i])
    );
  end

  plgr_div #(
    .NW(DIV_NW),
    .DW(W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quot)
  );

  assign cfg_ready_o  = 1'b1;
  assign in_stall_o   = (state_q != StIdle);
  assign out_valid_o  = out_v_q;
  assign sample_out_o = out_q;

endmodule

`default_nettype wire

// ----- rtl/plgr_cell.sv -----
// ----------------------------------------------------------------------------
// Window cell
// Holds one window slot; shifts up on a push and down on a rotation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plgr_cell import plgr_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cell_op_e                op_i,
  input  wire logic [SAMPLE_WIDTH-1:0] push_data_i,
  input  wire logic                    push_valid_i,
  input  wire logic [SAMPLE_WIDTH-1:0] rot_data_i,
  input  wire logic                    rot_valid_i,
  output      logic [SAMPLE_WIDTH-1:0] data_o,
  output      logic                    valid_o
);

  logic [SAMPLE_WIDTH-1:0] data_q, data_d;
  logic                    valid_q, valid_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    case (op_i)
      CELL_PUSH: begin
        data_d  = push_data_i;
        valid_d = push_valid_i;
      end
      CELL_ROT: begin
        data_d  = rot_data_i;
        valid_d = rot_valid_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ----- rtl/plgr_div.sv -----
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plgr_div #(
  parameter int unsigned NW = 33,
  parameter int unsigned DW = 24
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output      logic          done_o,
  output      logic [NW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] aq_q, aq_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          ge;

  assign rem_sh = {rem_q, aq_q[NW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    aq_d   = aq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      aq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so DW bits hold it.
      rem_d = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      aq_d  = {aq_q[NW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    aq_q  <= aq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = aq_q;

endmodule

`default_nettype wire

// ----- rtl/plgr_checker.sv -----
// ----------------------------------------------------------------------------
// Peak limiter gain ramp checker
// Port-level checks on the core, attached by a bind statement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "peak_limiter_gain_ramp_core_defines.svh"

module plgr_checker #(
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_stall_o,
  input wire logic                    out_valid_o,
  input wire logic                    out_stall_i,
  input wire logic [SAMPLE_WIDTH-1:0] sample_out_o
);

  // An accepted item keeps the core busy for at least the next cycle.
  `PLGR_ASSERT_NXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A new result only appears while an item is being worked on.
  `PLGR_ASSERT_IMP(a_out_from_busy, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

  // A stalled result stays offered.
  `PLGR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // A stalled result keeps its value.
  `PLGR_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(sample_out_o))

endmodule

bind peak_limiter_gain_ramp_core plgr_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_plgr_checker (.*);

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// Peak limiter gain ramp core testbench
// Drives samples and flushes with random gaps and stalls, predicts every
// limited sample from the window contents, and steps through several ramp
// widths, the extremes among them, while the core is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Scoreboard: keeps its own copy of the limiter window and the ramp width,
// and holds the limited samples that are still to leave the core.
class limiter_scoreboard;
  localparam int DEPTH = 128;
  localparam longint UNITY = 65536;

  longint        win_sample[DEPTH];
  bit            win_full[DEPTH];
  bit [6:0]      ramp_reg;
  logic [23:0]   limited_q[$];
  int            errors;
  int            peaks;
  int            results;

  function new();
    foreach (win_sample[i]) begin
      win_sample[i] = 0;
      win_full[i]   = 1'b0;
    end
    ramp_reg = 7'd8;
    errors   = 0;
    peaks    = 0;
    results  = 0;
  endfunction

  function void set_ramp(bit [6:0] v);
    ramp_reg = v;
  endfunction

  function int pending();
    return limited_q.size();
  endfunction

  // Shift one slot in, apply the ramp if the check slot is a peak, and
  // queue the slot that falls out at the far end of the window.
  function void note_input(bit kind, logic [23:0] raw);
    longint n, c, last, px, m, g, r, d, f, mag;
    n = (ramp_reg == 0) ? 1 : (ramp_reg > 64) ? 64 : ramp_reg;
    c = n - 1;
    last = 2 * n - 1;
    for (int s = DEPTH - 1; s > 0; s--) begin
      win_sample[s] = win_sample[s-1];
      win_full[s]   = win_full[s-1];
    end
    win_sample[0] = kind ? 0 : longint'($signed(raw));
    win_full[0]   = !kind;
    if (win_full[c]) begin
      px = win_sample[c];
      m  = (px < 0) ? -px : px;
      if (m > UNITY) begin
        peaks++;
        g = (64'd1 << 32) / m;
        r = (UNITY - g) / (n + 1);
        for (int s = 0; s <= last; s++) begin
          if (win_full[s]) begin
            d = (s > c) ? s - c : c - s;
            f = g + r * d;
            if (f > UNITY) f = UNITY;
            mag = win_sample[s] < 0 ? -win_sample[s] : win_sample[s];
            mag = (mag * f) >>> 16;
            win_sample[s] = (win_sample[s] < 0) ? -mag : mag;
          end
        end
        win_sample[c] = (px < 0) ? -UNITY : UNITY;
      end
    end
    if (win_full[last]) begin
      limited_q.push_back(win_sample[last][23:0]);
      win_full[last] = 1'b0;
    end
  endfunction

  function void check_result(logic [23:0] got);
    logic [23:0] want;
    results++;
    if (limited_q.size() == 0) begin
      $error("sample_out: unexpected transfer, actual %0d", $signed(got));
      errors++;
    end else begin
      want = limited_q.pop_front();
      if (got !== want) begin
        $error("sample_out: expected %0d, actual %0d", $signed(want), $signed(got));
        errors++;
      end
    end
  endfunction
endclass

module tb;
  import plgr_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  // Wait well past the worst item with a peak.
  localparam int SETTLE_CYCLES  = 400;
  localparam int HOLD_CYCLES    = 1000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  ramp_steps_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        kind_i = 1'b0;
  logic [23:0] sample_in_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [23:0] sample_out_o;

  limiter_scoreboard sb = new();

  // Random idling can be switched off to run stretches at full rate.
  bit no_idle = 1'b0;
  // One long receiver hold-off so the core backs up into its input.
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int items_sent = 0;
  int idle_count = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  peak_limiter_gain_ramp_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .ramp_steps_i (ramp_steps_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o)
  );

  // Monitor: sees pre-edge values, so every transfer is counted exactly once.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_ramp(ramp_steps_i);
      if (in_valid_i && !in_stall_o) sb.note_input(kind_i, sample_in_i);
      if (out_valid_o && !out_stall_i) sb.check_result(sample_out_o);
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && !in_stall_o) ||
          (out_valid_o && !out_stall_i)) begin
        idle_count <= 0;
      end else if (idle_count + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("peak_limiter_gain_ramp_core test failed");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
    end
  end

  // Receiver: stalls for a random number of cycles before each transfer.
  initial begin
    int gap;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Offers one item after a random gap; valid stays high across back-to-back
  // items so it is never lowered and raised in the same step.
  task automatic send_item(bit kind, logic [23:0] value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    sample_in_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Waits for every limited sample, then lets a peak pass in flight finish.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_ramp(bit [6:0] v);
    wait_drained();
    cfg_valid_i  <= 1'b1;
    ramp_steps_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Many musical levels, with some peaks, a few near unity and some
  // values from the whole range so every bit toggles.
  function automatic logic [23:0] pick_sample();
    int sel;
    logic [23:0] v;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: v = 24'($urandom_range(0, 65536));
      4, 5:       v = 24'(65536 + $urandom_range(0, 200));
      6:          v = 24'($urandom_range(65537, 8388607));
      7, 8:       v = 24'($urandom);
      default:    v = 24'($urandom_range(0, 3) == 0 ? 65537 : 65536);
    endcase
    if (sel < 7 && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic random_run(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(1'b1, 24'($urandom));
      else send_item(1'b0, pick_sample());
    end
  endtask

  initial begin
    logic [23:0] directed[$];
    directed = '{24'h7FFFFF, 24'h800000, 24'd65536, -24'sd65536, 24'd65537,
                 -24'sd65537, 24'd0, 24'd1, -24'sd1, 24'h000FFF, 24'hFFFFFF,
                 24'd131072, 24'd100, 24'd200};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset width: range extremes, unity on both sides
    // of the peak threshold, and a peak whose ramp spans a flushed gap.
    foreach (directed[i]) send_item(1'b0, directed[i]);
    send_item(1'b1, 24'h555555);
    send_item(1'b0, 24'd40000);
    send_item(1'b0, -24'sd300000);
    send_item(1'b1, 24'hAAAAAA);
    send_item(1'b0, 24'd50000);
    repeat (4) send_item(1'b1, 24'd0);

    random_run(100);
    write_ramp(7'd1);
    random_run(100);
    write_ramp(7'd64);
    random_run(180);
    write_ramp(7'd0);
    no_idle = 1'b1;
    random_run(80);
    no_idle = 1'b0;
    write_ramp(7'd127);
    random_run(160);
    write_ramp(7'd3);
    hold_req = 1'b1;
    random_run(100);
    write_ramp(7'($urandom_range(2, 63)));
    random_run(80);
    write_ramp(7'd8);
    no_idle = 1'b1;
    random_run(60);
    no_idle = 1'b0;

    wait_drained();
    $display("Sent %0d items (samples and flushes) over ramp widths 8, 1, 64, 0, 127, 3,",
             items_sent);
    $display("one random width and 8 again; %0d limited samples checked, %0d peaks.",
             sb.results, sb.peaks);
    if (sb.errors == 0) begin
      $display("peak_limiter_gain_ramp_core test passed");
    end else begin
      $display("peak_limiter_gain_ramp_core test failed");
    end
    $finish;
  end
endmodule
